[design/slcg_pkg.sv]
package slcg_pkg;

	// Generator constants.
	localparam int unsigned LCG_MOD = 714025;
	localparam int unsigned LCG_MUL = 1366;
	localparam int unsigned LCG_ADD = 150889;

	localparam int unsigned TABLE_SIZE = 97;
	localparam int unsigned SLOT_W     = $clog2(TABLE_SIZE);
	localparam int unsigned CNT_W      = $clog2(TABLE_SIZE + 1);

	localparam int unsigned VAL_W  = 20;
	localparam int unsigned SEED_W = 32;

	// The reduction unit takes a 32-bit operand. The quotient estimate uses the
	// operand without its low bits, times a scaled reciprocal of the modulus.
	localparam int unsigned OPND_W      = 32;
	localparam int unsigned DROP_W      = 10;
	localparam int unsigned RECIP_SHIFT = 30;
	localparam longint unsigned RECIP   =
		(64'd1 << (RECIP_SHIFT + DROP_W)) / 64'(LCG_MOD);
	localparam int unsigned RECIP_W = 21;
	localparam int unsigned PROD_W  = OPND_W - DROP_W + RECIP_W;
	localparam int unsigned Q_W     = PROD_W - RECIP_SHIFT;
	localparam int unsigned REM_W   = VAL_W + 1;

	typedef enum logic [1:0] {
		MODE_LCG,
		MODE_SLOT,
		MODE_SEED
	} modu_mode_t;

	typedef struct packed {
		logic                valid;
		modu_mode_t          mode;
		logic [OPND_W-1:0]   operand;
	} modu_req_t;

	typedef struct packed {
		logic              valid;
		logic [Q_W-1:0]    quot;
		logic [VAL_W-1:0]  rem;
	} modu_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SEED,
		ST_SEED_WAIT,
		ST_INIT_ISSUE,
		ST_INIT_WAIT,
		ST_SLOT,
		ST_STEP,
		ST_WAIT_SLOT,
		ST_WAIT_LCG,
		ST_OUT
	} state_t;

endpackage

[design/shuffled_lcg_random_generator_core.sv]
// Channel  Handshake                 Payload
// in       in_valid / in_stall       draw
// out      out_valid / out_stall     value, current_state
// cfg      cfg_valid / cfg_ready     seed
//
// No new input is taken until a draw has loaded its result into the output
// register. The first draw after reset or after a seed write first runs the seed
// reduction and 98 generator steps, one at a time through the pipelined
// reduction unit, filling the 97 table entries and then the held value.
// The result sits in an output register, so a stalled output does not hold
// the block while the next draw works; it waits only to load its own result.
// Reset clears the control state, the seed, the generator state and the held value.
module shuffled_lcg_random_generator_core
	import slcg_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               draw,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [VAL_W-1:0]   value,
	output logic [VAL_W-1:0]   current_state,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [SEED_W-1:0]  seed
);

	state_t             state_q, state_next;
	logic [SEED_W-1:0]  seed_q;
	logic               needs_init_q;
	logic [VAL_W-1:0]   lcg_q, held_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [SLOT_W-1:0]  slot_q;
	logic               out_valid_q;
	logic [VAL_W-1:0]   value_q, cur_q;

	modu_req_t          modu_req;
	modu_res_t          modu_res;
	logic               ram_we, ram_re;
	logic [SLOT_W-1:0]  ram_waddr, ram_raddr;
	logic [VAL_W-1:0]   ram_wdata, ram_rdata;
	logic [SLOT_W-1:0]  slot_pick;
	logic [SEED_W-1:0]  seed_dist;
	logic               out_load;

	slcg_modu u_modu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (modu_req),
		.res    (modu_res)
	);

	slcg_ram #(
		.WIDTH (VAL_W),
		.DEPTH (TABLE_SIZE)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign value         = value_q;
	assign current_state = cur_q;

	assign seed_dist = (seed_q <= SEED_W'(LCG_ADD)) ? (SEED_W'(LCG_ADD) - seed_q)
	                                                : (seed_q - SEED_W'(LCG_ADD));
	assign slot_pick = (modu_res.quot >= Q_W'(TABLE_SIZE)) ? SLOT_W'(TABLE_SIZE - 1)
	                                                       : modu_res.quot[SLOT_W-1:0];
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next       = state_q;
		modu_req.valid   = 1'b0;
		modu_req.mode    = MODE_LCG;
		modu_req.operand = OPND_W'(lcg_q);
		ram_we           = 1'b0;
		ram_waddr        = cnt_q[SLOT_W-1:0];
		ram_wdata        = modu_res.rem;
		ram_re           = 1'b0;
		ram_raddr        = slot_pick;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && draw) begin
					state_next = needs_init_q ? ST_SEED : ST_SLOT;
				end
			end
			ST_SEED: begin
				modu_req.valid   = 1'b1;
				modu_req.mode    = MODE_SEED;
				modu_req.operand = seed_dist;
				state_next       = ST_SEED_WAIT;
			end
			ST_SEED_WAIT: begin
				if (modu_res.valid) begin
					state_next = ST_INIT_ISSUE;
				end
			end
			ST_INIT_ISSUE: begin
				modu_req.valid = 1'b1;
				state_next     = ST_INIT_WAIT;
			end
			ST_INIT_WAIT: begin
				if (modu_res.valid) begin
					if (cnt_q == CNT_W'(TABLE_SIZE)) begin
						state_next = ST_SLOT;
					end else begin
						ram_we     = 1'b1;
						state_next = ST_INIT_ISSUE;
					end
				end
			end
			ST_SLOT: begin
				modu_req.valid   = 1'b1;
				modu_req.mode    = MODE_SLOT;
				modu_req.operand = OPND_W'(held_q);
				state_next       = ST_STEP;
			end
			ST_STEP: begin
				modu_req.valid = 1'b1;
				state_next     = ST_WAIT_SLOT;
			end
			ST_WAIT_SLOT: begin
				if (modu_res.valid) begin
					ram_re     = 1'b1;
					state_next = ST_WAIT_LCG;
				end
			end
			ST_WAIT_LCG: begin
				// The generator step result arrives in the cycle after the slot result, so it
				// lines up with the table read data.
				ram_we     = 1'b1;
				ram_waddr  = slot_q;
				state_next = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q       <= '0;
			needs_init_q <= 1'b1;
			lcg_q        <= '0;
			held_q       <= '0;
			cnt_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				seed_q       <= seed;
				needs_init_q <= 1'b1;
			end
			if (state_q == ST_SEED_WAIT && modu_res.valid) begin
				lcg_q <= modu_res.rem;
				cnt_q <= '0;
			end
			if (state_q == ST_INIT_WAIT && modu_res.valid) begin
				lcg_q <= modu_res.rem;
				if (cnt_q == CNT_W'(TABLE_SIZE)) begin
					held_q       <= modu_res.rem;
					needs_init_q <= 1'b0;
				end else begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
			end
			if (state_q == ST_WAIT_LCG) begin
				lcg_q  <= modu_res.rem;
				held_q <= ram_rdata;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_WAIT_SLOT && modu_res.valid) begin
			slot_q <= slot_pick;
		end
		if (out_load) begin
			value_q <= held_q;
			cur_q   <= lcg_q;
		end
	end

	a_out_from_sequencer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT)
		else $error("result appeared outside the output state");

	a_no_stray_result: assert property (@(posedge clk) disable iff (!arst_n)
		modu_res.valid |-> (state_q != ST_IDLE && state_q != ST_OUT))
		else $error("reduction result arrived with no step waiting for it");

	a_step_follows_slot: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_WAIT_LCG |-> modu_res.valid)
		else $error("generator step not aligned with table read");

	a_state_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(lcg_q < VAL_W'(LCG_MOD)) && (held_q < VAL_W'(LCG_MOD)))
		else $error("generator state or held value out of range");

	a_write_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> ram_waddr < SLOT_W'(TABLE_SIZE))
		else $error("table write beyond last entry");

endmodule

[design/slcg_ram.sv]
module slcg_ram #(
	parameter int unsigned WIDTH = 20,
	parameter int unsigned DEPTH = 97,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[design/slcg_modu.sv]
// Four-stage pipelined unit: forms the operand, then divides it by the modulus
// through a reciprocal estimate with one correction step. Returns both the
// quotient and the remainder.
module slcg_modu
	import slcg_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  modu_req_t req,
	output modu_res_t res
);

	logic              valid_s1, valid_s2, valid_s3, valid_s4;
	logic [OPND_W-1:0] v_s1, v_s2;
	logic [Q_W-1:0]    q_s2, q_s3, q_s4;
	logic [REM_W-1:0]  r_s3;
	logic [VAL_W-1:0]  r_s4;

	logic [OPND_W-1:0] v_next;
	logic [10:0]       mul_k;
	logic [VAL_W-1:0]  add_k;
	logic [PROD_W-1:0] est_prod;
	logic [OPND_W:0]   back_prod;
	logic [OPND_W-1:0] diff;

	always_comb begin
		mul_k = 11'(TABLE_SIZE);
		add_k = '0;
		if (req.mode == MODE_LCG) begin
			mul_k = 11'(LCG_MUL);
			add_k = VAL_W'(LCG_ADD);
		end
		if (req.mode == MODE_SEED) begin
			v_next = req.operand;
		end else begin
			v_next = OPND_W'(req.operand[VAL_W-1:0]) * OPND_W'(mul_k) + OPND_W'(add_k);
		end
	end

	assign est_prod  = PROD_W'(v_s1[OPND_W-1:DROP_W]) * PROD_W'(RECIP);
	assign back_prod = (OPND_W + 1)'(q_s2) * (OPND_W + 1)'(LCG_MOD);
	assign diff      = v_s2 - back_prod[OPND_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= req.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		v_s1 <= v_next;
		v_s2 <= v_s1;
		q_s2 <= est_prod[PROD_W-1:RECIP_SHIFT];
		// The estimate is the true quotient or one below it.
		q_s3 <= q_s2;
		r_s3 <= diff[REM_W-1:0];
		if (r_s3 >= REM_W'(LCG_MOD)) begin
			q_s4 <= q_s3 + Q_W'(1);
			r_s4 <= VAL_W'(r_s3 - REM_W'(LCG_MOD));
		end else begin
			q_s4 <= q_s3;
			r_s4 <= r_s3[VAL_W-1:0];
		end
	end

	assign res.valid = valid_s4;
	assign res.quot  = q_s4;
	assign res.rem   = r_s4;

endmodule

[sim/shuffled_lcg_random_generator_core_test.sv]
`timescale 1ns / 1ps

module shuffled_lcg_random_generator_core_test;
	import slcg_pkg::*;

	// Keeps its own copy of the generator and shuffle table and holds the
	// draws that are still owed by the block.
	class draw_scoreboard;
		localparam int unsigned MODULUS = 714025;
		localparam int unsigned MULT    = 1366;
		localparam int unsigned INC     = 150889;
		localparam int unsigned SLOTS   = 97;

		typedef struct packed {
			logic [VAL_W-1:0] value;
			logic [VAL_W-1:0] gen_state;
		} draw_t;

		draw_t     owed[$];
		bit [31:0] seed_reg;
		bit [19:0] slots[SLOTS];
		bit [19:0] gen;
		bit [19:0] held;
		bit        reseed;
		int        errors;
		int        checked;
		int        ignored;

		function new();
			seed_reg = '0;
			gen      = '0;
			held     = '0;
			reseed   = 1'b1;
			foreach (slots[i])
				slots[i] = '0;
		endfunction

		function bit [19:0] gen_next(input bit [19:0] x);
			bit [63:0] v;
			v = 64'(MULT) * 64'(x) + 64'(INC);
			return 20'(v % 64'(MODULUS));
		endfunction

		function void write_seed(input bit [31:0] s);
			seed_reg = s;
			reseed   = 1'b1;
		endfunction

		function void note_draw(input bit d);
			bit [31:0] start;
			bit [63:0] pick;
			draw_t     e;
			if (!d) begin
				ignored++;
				return;
			end
			if (reseed) begin
				if (seed_reg <= INC)
					start = (INC - seed_reg) % MODULUS;
				else
					start = (seed_reg - INC) % MODULUS;
				gen = 20'(start);
				foreach (slots[i]) begin
					gen      = gen_next(gen);
					slots[i] = gen;
				end
				gen    = gen_next(gen);
				held   = gen;
				reseed = 1'b0;
			end
			pick = (64'(SLOTS) * 64'(held)) / 64'(MODULUS);
			if (pick >= SLOTS)
				pick = SLOTS - 1;
			held              = slots[pick];
			gen               = gen_next(gen);
			slots[pick]       = gen;
			e.value           = held;
			e.gen_state       = gen;
			owed.push_back(e);
		endfunction

		function int pending();
			return owed.size();
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_result(input logic [VAL_W-1:0] v, input logic [VAL_W-1:0] s);
			draw_t e;
			if (owed.size() == 0) begin
				report($sformatf("unexpected result value=%0d state=%0d", v, s));
				return;
			end
			e = owed.pop_front();
			if (v !== e.value)
				report($sformatf("draw %0d: value %0d, expected %0d", checked, v, e.value));
			if (s !== e.gen_state)
				report($sformatf("draw %0d: current_state %0d, expected %0d",
					checked, s, e.gen_state));
			checked++;
		endtask
	endclass

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned IDLE_PCT    = 35;
	localparam int unsigned TAIL_CYCLES = 20;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic              draw = 1'b0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [VAL_W-1:0]  value;
	logic [VAL_W-1:0]  current_state;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [SEED_W-1:0] cfg_seed = '0;

	draw_scoreboard sb = new();
	bit             calm = 1'b0;
	int unsigned    cycles = 0;
	int             seed_writes = 0;

	shuffled_lcg_random_generator_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.draw          (draw),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.value         (value),
		.current_state (current_state),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.seed          (cfg_seed)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d draws owed", cycles, sb.pending());
			$display("Some tests failed");
			$finish;
		end
	end

	// Result side: check each transfer, then pick the next stall at random.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(value, current_state);
		out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
	end

	task automatic send_item(input bit d);
		if (!calm && $urandom_range(99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < IDLE_PCT);
		end
		in_valid <= 1'b1;
		draw     <= d;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_draw(d);
	endtask

	// Drops valid and waits for every owed draw to come back.
	task automatic drain();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (sb.pending() != 0);
	endtask

	task automatic settle();
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// A write that is followed by another keeps valid high between the two.
	task automatic write_seed(input logic [SEED_W-1:0] s, input bit last = 1'b1);
		cfg_valid <= 1'b1;
		cfg_seed  <= s;
		do
			@(posedge clk);
		while (!cfg_ready);
		if (last)
			cfg_valid <= 1'b0;
		sb.write_seed(s);
		seed_writes++;
	endtask

	task automatic run_draws(input int n, input int hold_at);
		int made;
		bit d;
		made = 0;
		while (made < n) begin
			if (made == hold_at)
				drain();
			d = ($urandom_range(99) >= 5);
			send_item(d);
			if (d)
				made++;
		end
	endtask

	initial begin : stimulus
		int p;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First draws use the seed left by reset.
		send_item(1'b0);
		send_item(1'b1);
		send_item(1'b1);
		send_item(1'b1);
		settle();
		// A seed equal to the increment starts the generator from zero.
		write_seed(32'd150889);
		send_item(1'b1);
		send_item(1'b1);
		send_item(1'b0);
		send_item(1'b1);
		settle();
		write_seed(32'd150888);
		send_item(1'b1);
		send_item(1'b1);
		settle();
		write_seed(32'hFFFF_FFFF);
		send_item(1'b1);
		send_item(1'b1);
		settle();
		// Seed above the increment whose difference is a whole modulus.
		write_seed(32'd864914);
		send_item(1'b1);
		send_item(1'b1);
		settle();
		// Back-to-back writes: only the second seed counts.
		write_seed(32'd7, 1'b0);
		write_seed(32'h8000_0000);
		send_item(1'b1);
		send_item(1'b1);
		settle();
		write_seed(32'd0);
		send_item(1'b1);
		send_item(1'b1);
		settle();

		for (p = 0; p < 6; p++) begin
			case (p)
				0: write_seed(32'hFFFF_FFFF);
				3: write_seed(32'd0);
				default: write_seed($urandom);
			endcase
			calm = (p == 2);
			run_draws(280, 140);
			settle();
		end
		calm = 1'b0;

		$display("Checked %0d draws over %0d seed writes; %0d idle requests were ignored.",
			sb.checked, seed_writes, sb.ignored);
		$display("Seeds covered both sides of the increment and the 32-bit extremes.");
		if (sb.errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
